// ===== rtl/pps_pkg.sv =====
`timescale 1ns / 1ps

package pps_pkg;

  // Width of the millisecond counters
  localparam int unsigned TIMER_BITS = 17;
  // Width of each timeout register
  localparam int unsigned CFG_W = 17;
  // Width used when a counter is compared against a register
  localparam int unsigned CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] TURN_ON_TIMEOUT_RST = CFG_W'(45000);
  localparam logic [CFG_W-1:0] COOL_DOWN_TIMEOUT_RST = CFG_W'(30000);
  localparam logic [CFG_W-1:0] WARM_UP_DELAY_RST = CFG_W'(15000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TURN_ON_TIMEOUT = 2'd0,
    REG_COOL_DOWN_TIMEOUT = 2'd1,
    REG_WARM_UP_DELAY = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_REPORT = 2'd1,
    OP_SET_INTENT = 2'd2,
    OP_POWER_CMD = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OFF = 3'd0,
    ST_UNKNOWN = 3'd1,
    ST_TURNING_ON = 3'd2,
    ST_WARMING = 3'd3,
    ST_ON = 3'd4,
    ST_COOLING = 3'd5,
    ST_TIMEOUT = 3'd6,
    ST_FAIL = 3'd7
  } status_e;

  typedef struct packed {
    op_e  operation;
    logic value_on;
  } in_item_t;

  typedef struct packed {
    status_e status;
    logic    intent_on;
    logic    send_valid;
    logic    send_on;
    logic    status_changed;
    logic    fail_event;
  } out_item_t;

endpackage

// ===== rtl/projector_power_supervisor.sv =====
`timescale 1ns / 1ps

// Projector power supervisor. Each beat on the input channel is a millisecond
// tick, a projector on/off report, a write of the commanded-on flag or a host
// power command; each produces exactly one result beat carrying the supervised
// status, the flag, an optional power command to send and event flags. One
// beat is accepted per clock while in_stall_o is low; the supervisor state
// updates at the accepting edge and the result goes to the result register,
// or to the skid register while the output stalls. This two-entry buffer lets
// one more beat in after the output stalls; in_stall_o rises only when both
// entries hold results. The user must write the three timeout registers via
// the plain write port only while the block is idle; the block does not
// enforce this. An index beyond the last register is ignored.
module projector_power_supervisor (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pps_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [pps_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  pps_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output pps_pkg::out_item_t                  out_data_o
);

  localparam logic [pps_pkg::TIMER_BITS-1:0] TIMER_MAX = {pps_pkg::TIMER_BITS{1'b1}};

  // Configuration registers
  logic [pps_pkg::CFG_W-1:0] turn_on_to_q, cool_down_to_q, warm_up_q;

  // Supervisor state
  pps_pkg::status_e                 status_q, status_d;
  logic                             intent_q, intent_d;
  logic [pps_pkg::TIMER_BITS-1:0]   cmd_ms_q, cmd_ms_d;
  logic [pps_pkg::TIMER_BITS-1:0]   warm_ms_q, warm_ms_d;

  // Output buffer
  logic               out_valid_q, skid_valid_q;
  pps_pkg::out_item_t out_data_q, skid_data_q;
  pps_pkg::out_item_t result;

  logic in_accept, out_take;
  logic cmd_issue, cmd_on;
  logic turn_on_expired, cool_down_expired, warm_done;

  assign in_stall_o  = skid_valid_q;
  assign in_accept   = in_valid_i & ~skid_valid_q;
  assign out_take    = out_valid_q & ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Compare counters against their limits (strictly greater)
  assign turn_on_expired   = pps_pkg::CMP_W'(cmd_ms_q) > pps_pkg::CMP_W'(turn_on_to_q);
  assign cool_down_expired = pps_pkg::CMP_W'(cmd_ms_q) > pps_pkg::CMP_W'(cool_down_to_q);
  assign warm_done         = pps_pkg::CMP_W'(warm_ms_q) > pps_pkg::CMP_W'(warm_up_q);

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_on_to_q   <= pps_pkg::TURN_ON_TIMEOUT_RST;
      cool_down_to_q <= pps_pkg::COOL_DOWN_TIMEOUT_RST;
      warm_up_q      <= pps_pkg::WARM_UP_DELAY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pps_pkg::REG_TURN_ON_TIMEOUT:   turn_on_to_q   <= cfg_wdata_i;
        pps_pkg::REG_COOL_DOWN_TIMEOUT: cool_down_to_q <= cfg_wdata_i;
        pps_pkg::REG_WARM_UP_DELAY:     warm_up_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Walk the supervisor table for one beat
  always_comb begin
    status_d  = status_q;
    intent_d  = intent_q;
    cmd_ms_d  = cmd_ms_q;
    warm_ms_d = warm_ms_q;
    cmd_issue = 1'b0;
    cmd_on    = 1'b0;
    result    = '0;

    unique case (in_data_i.operation)
      pps_pkg::OP_TICK: begin
        if (cmd_ms_q != TIMER_MAX) cmd_ms_d = cmd_ms_q + 1'b1;
        if (warm_ms_q != TIMER_MAX) warm_ms_d = warm_ms_q + 1'b1;
      end
      pps_pkg::OP_SET_INTENT: begin
        intent_d = in_data_i.value_on;
      end
      pps_pkg::OP_POWER_CMD: begin
        cmd_issue = 1'b1;
        cmd_on    = in_data_i.value_on;
      end
      pps_pkg::OP_REPORT: begin
        if (intent_q && !in_data_i.value_on) begin
          // Commanded on, projector reports off
          case (status_q) inside
            pps_pkg::ST_OFF, pps_pkg::ST_UNKNOWN, pps_pkg::ST_TIMEOUT, pps_pkg::ST_FAIL: begin
              cmd_issue = 1'b1;
              cmd_on    = 1'b1;
            end
            pps_pkg::ST_TURNING_ON: begin
              if (turn_on_expired) begin
                status_d          = pps_pkg::ST_TIMEOUT;
                result.fail_event = 1'b1;
                intent_d          = 1'b0;
              end
            end
            pps_pkg::ST_WARMING, pps_pkg::ST_ON: begin
              status_d          = pps_pkg::ST_FAIL;
              result.fail_event = 1'b1;
              intent_d          = 1'b0;
            end
            default: begin
              status_d = pps_pkg::ST_OFF;
            end
          endcase
          if (status_d != status_q || result.fail_event) result.status_changed = 1'b1;
        end else if (intent_q) begin
          // Commanded on, projector reports on
          case (status_q)
            pps_pkg::ST_TURNING_ON: begin
              status_d              = pps_pkg::ST_WARMING;
              warm_ms_d             = '0;
              result.status_changed = 1'b1;
            end
            pps_pkg::ST_WARMING: begin
              if (warm_done) begin
                status_d              = pps_pkg::ST_ON;
                result.status_changed = 1'b1;
              end
            end
            pps_pkg::ST_ON: ;
            default: begin
              status_d              = pps_pkg::ST_ON;
              result.status_changed = 1'b1;
            end
          endcase
        end else if (!in_data_i.value_on) begin
          // Commanded off, projector reports off
          if (status_q != pps_pkg::ST_OFF) begin
            status_d              = pps_pkg::ST_OFF;
            result.status_changed = 1'b1;
          end
        end else begin
          // Commanded off, projector reports on
          case (status_q)
            pps_pkg::ST_COOLING: begin
              if (cool_down_expired) begin
                status_d              = pps_pkg::ST_ON;
                result.status_changed = 1'b1;
              end
            end
            pps_pkg::ST_OFF: begin
              intent_d  = 1'b1;
              cmd_issue = 1'b1;
              cmd_on    = 1'b1;
            end
            default: begin
              cmd_issue = 1'b1;
              cmd_on    = 1'b0;
            end
          endcase
        end
      end
      default: ;
    endcase

    // Apply a power command
    if (cmd_issue) begin
      status_d              = cmd_on ? pps_pkg::ST_TURNING_ON : pps_pkg::ST_COOLING;
      cmd_ms_d              = '0;
      result.send_valid     = 1'b1;
      result.send_on        = cmd_on;
      result.status_changed = 1'b1;
    end

    result.status    = status_d;
    result.intent_on = intent_d;
  end

  // Advance supervisor state on an accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q  <= pps_pkg::ST_UNKNOWN;
      intent_q  <= 1'b0;
      cmd_ms_q  <= '0;
      warm_ms_q <= '0;
    end else if (in_accept) begin
      status_q  <= status_d;
      intent_q  <= intent_d;
      cmd_ms_q  <= cmd_ms_d;
      warm_ms_q <= warm_ms_d;
    end
  end

  // Hold results in the output register and the skid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_take || !out_valid_q) begin
      out_valid_q  <= skid_valid_q | in_accept;
      skid_valid_q <= 1'b0;
    end else if (in_accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take || !out_valid_q) begin
      out_data_q <= skid_valid_q ? skid_data_q : result;
    end
    if (in_accept && out_valid_q && !out_take) begin
      skid_data_q <= result;
    end
  end

endmodule

// ===== rtl/pps_checker.sv =====
`timescale 1ns / 1ps

module pps_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input pps_pkg::out_item_t out_data_o
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // Input stalls only when a result is already waiting
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // A failure drops the intent flag and lands in timeout or fail
  a_fail_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.fail_event |->
      !out_data_o.intent_on && out_data_o.status_changed &&
      (out_data_o.status == pps_pkg::ST_TIMEOUT || out_data_o.status == pps_pkg::ST_FAIL))
    else $error("fail event with wrong status or intent");

  // A sent command moves the status to turning on or cooling to match
  a_cmd_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.send_valid |->
      out_data_o.status_changed &&
      ((out_data_o.send_on && out_data_o.status == pps_pkg::ST_TURNING_ON) ||
       (!out_data_o.send_on && out_data_o.status == pps_pkg::ST_COOLING)))
    else $error("power command inconsistent with status");

  // No command value without a command
  a_cmd_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.send_valid |-> !out_data_o.send_on && !out_data_o.fail_event ||
      out_valid_o && !out_data_o.send_valid && !out_data_o.send_on)
    else $error("send_on set without send_valid");

endmodule

bind projector_power_supervisor pps_checker u_pps_checker (.*);
